// File: rtl/core/tksk_pkg.sv
// ----------------------------------------------------------------------------
// tksk_pkg: shared types and constants of the top-K score keeper
// Sizes of the ranked list, item layouts, and the id and slot conversions.
// ----------------------------------------------------------------------------
package tksk_pkg;

  localparam int MAX_KEPT   = 16;  // cells in the ranked row
  localparam int ID_BITS    = 16;  // id bits kept per cell
  localparam int OUT_LIMIT  = 16;  // most entries sent by one readout
  localparam int FIELD_ID_W = 16;
  localparam int SCORE_W    = 32;
  localparam int SLOT_W     = 4;
  localparam int LIM_W      = 5;
  localparam int LIM_RESET  = 10;

  localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int COUNT_W = $clog2(MAX_KEPT + 1);
  localparam int CMP_W   = (COUNT_W > LIM_W) ? COUNT_W : LIM_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef logic [ID_BITS-1:0]        kid_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  typedef struct packed {
    kid_t   id;
    score_t score;
  } cand_t;

  typedef struct packed {
    logic cmp_en;  // latch the compare flag against the arriving score
    logic ins_en;  // open a gap at the insert point and shift the tail
    logic rot_en;  // rotate the row by one toward cell 0
  } cell_ctrl_t;

  typedef struct packed {
    logic             drop;
    logic [IDX_W-1:0] pos;
    kid_t             ev_id;
    cand_t            head;
  } row_stat_t;

  typedef struct packed {
    logic                  accepted;
    logic [SLOT_W-1:0]     slot;
    logic                  evicted;
    logic [FIELD_ID_W-1:0] evicted_id;
    logic                  entry_valid;
    logic [FIELD_ID_W-1:0] entry_id;
    logic [SCORE_W-1:0]    entry_score;
    logic                  last;
  } rsp_item_t;

  function automatic kid_t id_in(input logic [FIELD_ID_W-1:0] x);
    kid_t r;
    r = '0;
    for (int b = 0; b < ID_BITS; b++) begin
      if (b < FIELD_ID_W) r[b] = x[b];
    end
    return r;
  endfunction

  function automatic logic [FIELD_ID_W-1:0] id_out(input kid_t x);
    logic [FIELD_ID_W-1:0] r;
    r = '0;
    for (int b = 0; b < FIELD_ID_W; b++) begin
      if (b < ID_BITS) r[b] = x[b];
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] x);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int b = 0; b < SLOT_W; b++) begin
      if (b < IDX_W) r[b] = x[b];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/tksk_req_if.sv
// ----------------------------------------------------------------------------
// tksk_req_if: request channel of the top-K score keeper
// Valid/ready channel carrying one insert or readout item.
// ----------------------------------------------------------------------------
interface tksk_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] cand_id;
  logic signed [31:0] cand_score;

  modport source (output valid, kind, cand_id, cand_score, input ready);
  modport sink   (input valid, kind, cand_id, cand_score, output ready);
endinterface

// File: rtl/core/tksk_rsp_if.sv
// ----------------------------------------------------------------------------
// tksk_rsp_if: result channel of the top-K score keeper
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tksk_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  slot;
  logic        evicted;
  logic [15:0] evicted_id;
  logic        entry_valid;
  logic [15:0] entry_id;
  logic signed [31:0] entry_score;
  logic        last;

  modport source (output valid, accepted, slot, evicted, evicted_id, entry_valid,
                  entry_id, entry_score, last, input ready);
  modport sink   (input valid, accepted, slot, evicted, evicted_id, entry_valid,
                  entry_id, entry_score, last, output ready);
endinterface

// File: rtl/core/tksk_cell.sv
// ----------------------------------------------------------------------------
// tksk_cell: one rank position of the list
// Holds an id and score, compares against an arriving score, and takes
// data from its left neighbor on insert or its right neighbor on rotate.
// ----------------------------------------------------------------------------
module tksk_cell (
  input  logic                clk,
  input  logic                rst,
  input  tksk_pkg::cell_ctrl_t ctrl,
  input  logic                active,   // position is below the kept count
  input  logic                ge_left,  // left neighbor scores >= candidate
  input  tksk_pkg::score_t    cmp_score,
  input  tksk_pkg::cand_t     cand,
  input  tksk_pkg::cand_t     left,
  input  tksk_pkg::cand_t     right,
  output tksk_pkg::cand_t     data,
  output logic                ge
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ge <= 1'b0;
    end else if (ctrl.cmp_en) begin
      ge <= active && ($signed(data.score) >= $signed(cmp_score));
    end
  end

  // entries at or above the candidate stay; the first one below takes the
  // candidate, the rest shift one place down
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (!ge) data <= ge_left ? cand : left;
    end else if (ctrl.rot_en) begin
      data <= right;
    end
  end

endmodule

// File: rtl/core/tksk_row.sv
// ----------------------------------------------------------------------------
// tksk_row: the chain of rank cells
// Wires the cells to their neighbors and derives insert point, drop and
// eviction id from the registered compare flags.
// ----------------------------------------------------------------------------
module tksk_row (
  input  logic                          clk,
  input  logic                          rst,
  input  tksk_pkg::cell_ctrl_t          ctrl,
  input  logic [tksk_pkg::COUNT_W-1:0]  count,
  input  logic [tksk_pkg::COUNT_W-1:0]  cap,
  input  tksk_pkg::score_t              cmp_score,
  input  tksk_pkg::cand_t               cand,
  output tksk_pkg::row_stat_t           stat
);

  localparam int N = tksk_pkg::MAX_KEPT;

  tksk_pkg::cand_t        data [N];
  logic [N-1:0]           ge;
  logic [N-1:0]           ge_left;
  logic [tksk_pkg::COUNT_W-1:0] cap_m1;
  logic [tksk_pkg::COUNT_W-1:0] count_m1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i + 1) % N;

    assign ge_left[i] = (i == 0) ? 1'b1 : ge[L];

    tksk_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .active    (tksk_pkg::COUNT_W'(i) < count),
      .ge_left   (ge_left[i]),
      .cmp_score (cmp_score),
      .cand      (cand),
      .left      (data[L]),
      .right     (data[R]),
      .data      (data[i]),
      .ge        (ge[i])
    );
  end

  assign cap_m1   = cap - tksk_pkg::COUNT_W'(1);
  assign count_m1 = count - tksk_pkg::COUNT_W'(1);

  always_comb begin
    stat       = '0;
    stat.head  = data[0];
    // flags form a prefix, so the insert point is its first clear bit
    stat.drop  = (cap == '0) || ge[cap_m1[tksk_pkg::IDX_W-1:0]];
    for (int i = 0; i < N; i++) begin
      if (!ge[i] && ge_left[i]) stat.pos = stat.pos | tksk_pkg::IDX_W'(i);
      if (count_m1[tksk_pkg::IDX_W-1:0] == tksk_pkg::IDX_W'(i)) begin
        stat.ev_id = stat.ev_id | data[i].id;
      end
    end
  end

endmodule

// File: rtl/core/top_k_score_keeper.sv
// ----------------------------------------------------------------------------
// top_k_score_keeper: ranked list of the best-scoring candidates
// Sorted insert with eviction, and in-order readout, on a row of cells.
// ----------------------------------------------------------------------------
// Keeps up to min(keep_limit, MAX_KEPT) candidates, best score first; ties
// keep arrival order. An insert item latches every cell's compare flag on
// the accepting edge; then, in S_INS once the output register is free, the
// tail shifts, the slot opens, and the one result item is loaded into the
// output register. After a readout item is accepted, the row rotates once
// through cell 0, one place per cycle while no result stalls, sending the
// first min(count, 16) entries as result items. An empty list sends one
// invalid item without rotating. A stalled result holds the insert, or the
// rotation while entries remain to be sent. A new request item is accepted
// while a finished result still waits in the output register.
// keep_limit is written through cfg_we/cfg_wdata; the user must write it only while the block is idle, unenforced.
module top_k_score_keeper (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tksk_pkg::LIM_W-1:0]   cfg_wdata,
  tksk_req_if.sink                     req,
  tksk_rsp_if.source                   rsp
);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_READ} state_t;

  state_t                         state;
  logic [tksk_pkg::LIM_W-1:0]     keep_limit;
  logic [tksk_pkg::COUNT_W-1:0]   kept_count;
  logic [tksk_pkg::IDX_W-1:0]     step;
  tksk_pkg::cand_t                cand;
  logic                           rsp_valid;
  tksk_pkg::rsp_item_t            rsp_q;

  tksk_pkg::cell_ctrl_t           ctrl;
  tksk_pkg::row_stat_t            stat;
  tksk_pkg::rsp_item_t            item;
  logic                           emit;
  logic                           free;
  logic                           req_acc;
  logic                           ev;
  logic                           read_done;
  logic [tksk_pkg::CMP_W-1:0]     lim_ext;
  logic [tksk_pkg::CMP_W-1:0]     cap_ext;
  logic [tksk_pkg::CMP_W-1:0]     count_ext;
  logic [tksk_pkg::CMP_W-1:0]     n_ext;
  logic [tksk_pkg::CMP_W-1:0]     step_ext;
  logic [tksk_pkg::COUNT_W-1:0]   cap;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign free      = !rsp_valid || rsp.ready;

  // effective capacity, clamped to the row length
  assign lim_ext   = tksk_pkg::CMP_W'(keep_limit);
  assign cap_ext   = (lim_ext > tksk_pkg::CMP_W'(tksk_pkg::MAX_KEPT)) ?
                     tksk_pkg::CMP_W'(tksk_pkg::MAX_KEPT) : lim_ext;
  assign cap       = cap_ext[tksk_pkg::COUNT_W-1:0];

  // readout length
  assign count_ext = tksk_pkg::CMP_W'(kept_count);
  assign n_ext     = (count_ext > tksk_pkg::CMP_W'(tksk_pkg::OUT_LIMIT)) ?
                     tksk_pkg::CMP_W'(tksk_pkg::OUT_LIMIT) : count_ext;
  assign step_ext  = tksk_pkg::CMP_W'(step);

  // a full list pushes out its last entry; a lowered capacity keeps the count
  assign ev = !stat.drop && (kept_count >= cap);

  tksk_row u_row (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .count     (kept_count),
    .cap       (cap),
    .cmp_score (req.cand_score),
    .cand      (cand),
    .stat      (stat)
  );

  always_comb begin
    ctrl      = '0;
    emit      = 1'b0;
    item      = '0;
    item.last = 1'b1;
    read_done = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.cmp_en = req_acc && (req.kind == tksk_pkg::KIND_INSERT);
      end
      S_INS: begin
        if (free) begin
          emit        = 1'b1;
          ctrl.ins_en = !stat.drop;
          if (!stat.drop) begin
            item.accepted   = 1'b1;
            item.slot       = tksk_pkg::slot_of(stat.pos);
            item.evicted    = ev;
            item.evicted_id = ev ? tksk_pkg::id_out(stat.ev_id) : '0;
          end
        end
      end
      S_READ: begin
        if (n_ext == '0) begin
          emit      = free;
          read_done = free;
        end else if (step_ext < n_ext) begin
          // live entry at the head: wait for room, then send and rotate
          emit             = free;
          ctrl.rot_en      = free;
          item.slot        = tksk_pkg::slot_of(step);
          item.entry_valid = 1'b1;
          item.entry_id    = tksk_pkg::id_out(stat.head.id);
          item.entry_score = stat.head.score;
          item.last        = (step_ext + tksk_pkg::CMP_W'(1) == n_ext);
        end else begin
          // remaining turns only restore the order
          ctrl.rot_en = 1'b1;
        end
        if (ctrl.rot_en && (step == tksk_pkg::IDX_W'(tksk_pkg::MAX_KEPT - 1))) begin
          read_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keep_limit <= tksk_pkg::LIM_W'(tksk_pkg::LIM_RESET);
      kept_count <= '0;
      step       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) keep_limit <= cfg_wdata;

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            step  <= '0;
            state <= (req.kind == tksk_pkg::KIND_INSERT) ? S_INS : S_READ;
          end
        end
        S_INS: begin
          if (free) begin
            if (!stat.drop && !ev) kept_count <= kept_count + tksk_pkg::COUNT_W'(1);
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (ctrl.rot_en) step <= step + tksk_pkg::IDX_W'(1);
          if (read_done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (emit) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  // candidate and result payload
  always_ff @(posedge clk) begin
    if (req_acc) begin
      cand.id    <= tksk_pkg::id_in(req.cand_id);
      cand.score <= req.cand_score;
    end
    if (emit) rsp_q <= item;
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.accepted    = rsp_q.accepted;
  assign rsp.slot        = rsp_q.slot;
  assign rsp.evicted     = rsp_q.evicted;
  assign rsp.evicted_id  = rsp_q.evicted_id;
  assign rsp.entry_valid = rsp_q.entry_valid;
  assign rsp.entry_id    = rsp_q.entry_id;
  assign rsp.entry_score = rsp_q.entry_score;
  assign rsp.last        = rsp_q.last;

endmodule

// File: rtl/core/tksk_checker.sv
// ----------------------------------------------------------------------------
// tksk_checker: port-level checks of the top-K score keeper
// Watches the result channel and the shape of each result item.
// ----------------------------------------------------------------------------
module tksk_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        accepted,
  input logic [3:0]  slot,
  input logic        evicted,
  input logic        entry_valid,
  input logic        last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_insert_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && accepted |-> last && !entry_valid)
    else $error("insert result not single or carries an entry");

  a_evict_needs_accept: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evicted |-> accepted)
    else $error("eviction without placement");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !accepted && !entry_valid |-> last && (slot == 4'd0))
    else $error("drop or empty readout result malformed");

endmodule

bind top_k_score_keeper tksk_checker u_tksk_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .accepted    (rsp.accepted),
  .slot        (rsp.slot),
  .evicted     (rsp.evicted),
  .entry_valid (rsp.entry_valid),
  .last        (rsp.last)
);
